@@ design/dnp3_lfr_pkg.sv @@
// Shared types, constants and CRC helper for the DNP3 link frame responder.
package dnp3_lfr_pkg;

  localparam int unsigned StoreBytesDef = 16;

  localparam logic [15:0] CrcPoly = 16'hA6BC;

  localparam logic [3:0] LinkFnReset = 4'h0;
  localparam logic [3:0] LinkFnUser  = 4'h4;

  localparam logic [7:0] AppFnConfirm = 8'h00;
  localparam logic [7:0] AppFnRead    = 8'h01;
  localparam logic [7:0] AppFnWrite   = 8'h02;
  localparam logic [7:0] AppFnDelay   = 8'h17;

  localparam logic [1:0] RegLocal  = 2'd0;
  localparam logic [1:0] RegRemote = 2'd1;
  localparam logic [1:0] RegMaster = 2'd2;

  typedef enum logic [2:0] {
    FrmNone  = 3'd0,
    FrmAck   = 3'd1,
    FrmNull  = 3'd2,
    FrmDelay = 3'd3,
    FrmReset = 3'd4,
    FrmPoll  = 3'd5
  } frame_kind_e;

  typedef enum logic [2:0] {
    StIdle  = 3'd0,
    StJudge = 3'd1,
    StCrcH  = 3'd2,
    StCrcU  = 3'd3,
    StSend  = 3'd4,
    StClear = 3'd5
  } state_e;

  // Command from controller to datapath
  typedef struct packed {
    logic        store_byte;
    logic        start_judge;
    logic        start_frame;
    frame_kind_e kind;
    logic        crc_step;
    logic        crc_latch_hdr;
    logic        crc_latch_usr;
    logic        send_step;
    logic        clear;
    logic        err_out;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    frame_kind_e verdict;
    logic        crc_bad;
    logic        crc_done_hdr;
    logic        crc_done_usr;
    logic        send_last;
    logic        has_user;
  } dp_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/dnp3_lfr_datapath.sv @@
// Datapath: frame store, frame builder, CRC unit and station state.
module dnp3_lfr_datapath import dnp3_lfr_pkg::*; #(
  parameter int unsigned StoreBytes = StoreBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] local_address_i,
  input  logic [15:0] remote_address_i,
  input  logic        master_mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        poll_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        event_res_o
);

  localparam int unsigned CntW = $clog2(StoreBytes + 1);
  localparam int unsigned IdxW = $clog2(StoreBytes);

  logic [7:0]      store_q [StoreBytes];
  logic [CntW-1:0] cnt_q;
  logic [7:0]      iin_byte_q;
  logic [3:0]      app_seq_q;
  logic [5:0]      tp_seq_q;
  logic            reset_pend_q;
  logic            sync_pend_q;

  // Built frame: 27 bytes max
  logic [7:0]  frm_q [27];
  logic [4:0]  flen_q;
  logic [4:0]  ptr_q;
  logic [15:0] crc_q;
  logic [4:0]  cend_q;
  frame_kind_e verdict_d;
  logic        crc_bad_d;

  function automatic logic [7:0] st(input int unsigned i);
    return (i < StoreBytes) ? store_q[i[IdxW-1:0]] : 8'h00;
  endfunction

  // Header CRC of stored bytes 0..7, computed combinationally from a
  // two-byte chain per cycle is overkill; the CRC unit walks frm_q instead,
  // so the receive check copies the header into frm_q first.
  logic [15:0] ov;
  logic [7:0]  fn;
  logic        ov_rd;
  always_comb begin
    fn = st(12);
    ov = {st(13), st(14)};
    ov_rd = (ov >= 16'h3C01 && ov <= 16'h3C04) || ov == 16'h0100 || ov == 16'h0A00 ||
            (ov >= 16'h2800 && ov <= 16'h2802);
    verdict_d = FrmNone;
    crc_bad_d = ~(crc_q == {st(9), st(8)});
    if (!crc_bad_d && {st(7), st(6)} == remote_address_i &&
        {st(5), st(4)} == local_address_i && !master_mode_i) begin
      if (st(3)[3:0] == LinkFnReset) begin
        verdict_d = FrmAck;
      end else if (st(3)[3:0] == LinkFnUser) begin
        if ((fn == AppFnConfirm || fn == AppFnRead) && ov_rd) verdict_d = FrmNull;
        else if (fn == AppFnWrite && (ov == 16'h5001 || ov == 16'h3201)) verdict_d = FrmNull;
        else if (fn == AppFnDelay) verdict_d = FrmDelay;
      end
    end
    if (poll_i) begin
      if (!master_mode_i || (!reset_pend_q && sync_pend_q)) verdict_d = FrmNone;
      else if (reset_pend_q) verdict_d = FrmReset;
      else verdict_d = FrmPoll;
    end
  end

  logic [7:0] crc_in;
  assign crc_in = frm_q[ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      iin_byte_q   <= 8'h10;
      app_seq_q    <= '0;
      tp_seq_q     <= '0;
      reset_pend_q <= 1'b1;
      sync_pend_q  <= 1'b1;
      for (int i = 0; i < StoreBytes; i++) store_q[i] <= '0;
      ptr_q  <= '0;
      flen_q <= '0;
      crc_q  <= '0;
      cend_q <= '0;
    end else begin
      if (cmd_i.store_byte && cnt_q < CntW'(StoreBytes)) begin
        store_q[cnt_q[IdxW-1:0]] <= rx_byte_i;
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.clear) begin
        for (int i = 0; i < StoreBytes; i++) store_q[i] <= '0;
        cnt_q <= '0;
      end
      // Start a receive check: load header bytes into builder, run CRC over 8
      if (cmd_i.start_judge) begin
        for (int i = 0; i < 8; i++) frm_q[i] <= st(i);
        ptr_q  <= '0;
        cend_q <= 5'd8;
        crc_q  <= '0;
      end
      if (cmd_i.crc_step) begin
        crc_q <= crc_byte(crc_q, crc_in);
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.crc_latch_hdr) begin
        if (cend_q == 5'd8 && flen_q == 5'd0) begin
          crc_q <= crc_q ^ 16'hFFFF;
        end
      end
      if (cmd_i.start_frame) begin
        crc_q <= '0;
        ptr_q <= '0;
        cend_q <= 5'd8;
        frm_q[0] <= 8'h05;
        frm_q[1] <= 8'h64;
        frm_q[4] <= remote_address_i[7:0];
        frm_q[5] <= remote_address_i[15:8];
        frm_q[6] <= local_address_i[7:0];
        frm_q[7] <= local_address_i[15:8];
        for (int i = 8; i < 27; i++) frm_q[i] <= 8'h00;
        case (cmd_i.kind)
          FrmAck: begin
            frm_q[2] <= 8'h05; frm_q[3] <= 8'h00; flen_q <= 5'd10;
          end
          FrmReset: begin
            frm_q[2] <= 8'h05; frm_q[3] <= 8'hC0; flen_q <= 5'd10;
          end
          FrmNull: begin
            frm_q[2] <= 8'h0A; frm_q[3] <= 8'h44; flen_q <= 5'd17;
            tp_seq_q <= '0;
            app_seq_q <= app_seq_q + 1'b1;
            frm_q[10] <= 8'hC0;
            frm_q[11] <= {4'hC, app_seq_q + 4'd1};
            frm_q[12] <= 8'h81;
            if (fn == AppFnWrite && ov == 16'h3201) begin
              frm_q[13] <= 8'h00; iin_byte_q <= 8'h00;
            end else begin
              frm_q[13] <= iin_byte_q;
            end
          end
          FrmDelay: begin
            frm_q[2] <= 8'h10; frm_q[3] <= 8'h44; flen_q <= 5'd23;
            tp_seq_q <= tp_seq_q + 1'b1;
            app_seq_q <= app_seq_q + 1'b1;
            frm_q[10] <= {2'b11, tp_seq_q + 6'd1};
            frm_q[11] <= {4'hC, app_seq_q + 4'd1};
            frm_q[12] <= 8'h81; frm_q[13] <= 8'h10; frm_q[14] <= 8'h00;
            frm_q[15] <= 8'h34; frm_q[16] <= 8'h02; frm_q[17] <= 8'h07;
            frm_q[18] <= 8'h01; frm_q[19] <= 8'h00; frm_q[20] <= 8'h00;
          end
          FrmPoll: begin
            frm_q[2] <= 8'h14; frm_q[3] <= 8'hF3; flen_q <= 5'd27;
            tp_seq_q <= '0;
            app_seq_q <= app_seq_q + 1'b1;
            frm_q[10] <= 8'hC0;
            frm_q[11] <= {4'hC, app_seq_q + 4'd1};
            frm_q[12] <= 8'h01; frm_q[13] <= 8'h3C; frm_q[14] <= 8'h04;
            frm_q[15] <= 8'h06; frm_q[16] <= 8'h3C; frm_q[17] <= 8'h03;
            frm_q[18] <= 8'h06; frm_q[19] <= 8'h3C; frm_q[20] <= 8'h02;
            frm_q[21] <= 8'h06; frm_q[22] <= 8'h3C; frm_q[23] <= 8'h01;
            frm_q[24] <= 8'h06;
          end
          default: flen_q <= '0;
        endcase
      end
      // Side effects that give no frame
      if (cmd_i.start_judge) begin
        flen_q <= '0;
      end
      if (cmd_i.start_frame) begin
        if (!crc_bad_d && master_mode_i && !poll_i &&
            {st(7), st(6)} == remote_address_i && {st(5), st(4)} == local_address_i &&
            st(3)[3:0] == LinkFnReset)
          reset_pend_q <= 1'b0;
        if (poll_i && master_mode_i && !reset_pend_q && sync_pend_q)
          sync_pend_q <= 1'b0;
      end
      // Store the finished CRC into the frame; rewind to the user block or the start
      if (cmd_i.crc_latch_usr) begin
        frm_q[cend_q]     <= ~crc_q[7:0];
        frm_q[cend_q + 5'd1] <= ~crc_q[15:8];
        ptr_q  <= (flen_q > 5'd10 && cend_q == 5'd8) ? 5'd10 : 5'd0;
        crc_q  <= '0;
        cend_q <= flen_q - 5'd2;
      end
      if (cmd_i.send_step) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  assign sts_o.verdict      = verdict_d;
  assign sts_o.crc_bad      = crc_bad_d;
  assign sts_o.crc_done_hdr = (ptr_q == 5'd7);
  assign sts_o.crc_done_usr = (ptr_q == cend_q - 5'd1);
  assign sts_o.send_last    = (ptr_q == flen_q - 5'd1);
  assign sts_o.has_user     = (flen_q > 5'd10) && (cend_q == 5'd8);

  assign tx_byte_o   = cmd_i.err_out ? 8'h00 : frm_q[ptr_q];
  assign tx_last_o   = cmd_i.err_out ? 1'b1 : (ptr_q == flen_q - 5'd1);
  assign event_res_o = cmd_i.err_out;

endmodule

@@ design/dnp3_lfr_ctrl.sv @@
// Controller state machine sequencing receive, judge, CRC and send.
module dnp3_lfr_ctrl import dnp3_lfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    kind_i,
  input  logic    last_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output logic    poll_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   poll_q, poll_d;
  logic   err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      poll_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      poll_q  <= poll_d;
      err_q   <= err_d;
    end
  end

  assign poll_o = poll_q;

  always_comb begin
    state_d     = state_q;
    poll_d      = poll_q;
    err_d       = err_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i) begin
            poll_d  = 1'b1;
            state_d = StJudge;
          end else begin
            cmd_o.store_byte = 1'b1;
            poll_d = 1'b0;
            if (last_i) begin
              state_d = StCrcH;
            end
          end
        end
      end
      StCrcH: begin
        // Header CRC of stored bytes, one byte per cycle
        if (!err_q) begin
          cmd_o.start_judge = 1'b1;
          err_d = 1'b1;
        end else begin
          cmd_o.crc_step = 1'b1;
          if (sts_i.crc_done_hdr) begin
            err_d = 1'b0;
            state_d = StJudge;
          end
        end
      end
      StJudge: begin
        if (!err_q) begin
          cmd_o.crc_latch_hdr = 1'b1;
          err_d = 1'b1;
        end else begin
          cmd_o.err_out = 1'b1;
          if (!poll_q && sts_i.crc_bad) begin
            out_valid_o = 1'b1;
            if (out_ready_i) begin
              err_d = 1'b0;
              state_d = StClear;
            end
          end else begin
            cmd_o.err_out = 1'b0;
            err_d = 1'b0;
            cmd_o.start_frame = 1'b1;
            cmd_o.kind = sts_i.verdict;
            state_d = (sts_i.verdict == FrmNone) ? StClear : StCrcU;
          end
        end
      end
      StCrcU: begin
        cmd_o.crc_step = 1'b1;
        if (sts_i.crc_done_usr) begin
          cmd_o.crc_step = 1'b1;
          state_d = StSend;
          err_d = 1'b1;
        end
      end
      StSend: begin
        if (err_q) begin
          // write the CRC just finished, then either hash the user block or send
          cmd_o.crc_latch_usr = 1'b1;
          err_d = 1'b0;
          state_d = sts_i.has_user ? StCrcU : StSend;
        end else begin
          out_valid_o = 1'b1;
          if (out_ready_i) begin
            cmd_o.send_step = 1'b1;
            if (sts_i.send_last) state_d = StClear;
          end
        end
      end
      StClear: begin
        if (!poll_q) cmd_o.clear = 1'b1;
        poll_d  = 1'b0;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("input taken while a word is on offer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |=> (state_q == StIdle))
    else $error("clear did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("offered word withdrawn");

endmodule

@@ design/dnp3_link_frame_responder_unit.sv @@
// Top level of the DNP3 link frame responder.
// Frame bytes that are not the last are taken back to back while the unit is idle;
// a poll request goes straight to the judge. After the last byte the CRC unit walks
// the eight header bytes and the frame is judged; a bad CRC gives an error word, else
// a response frame, if any, is built and its CRCs computed byte-serially; it is then
// sent one byte per cycle while output is ready. Input waits until the clear state ends.
// Reset clears the store and sequence numbers, sets both pending flags and the IIN byte.
module dnp3_link_frame_responder_unit import dnp3_lfr_pkg::*; #(
  parameter int unsigned StoreBytes = StoreBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // rx_byte
  input  logic        s_axis_tuser,  // kind
  input  logic        s_axis_tlast,  // rx_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // tx_byte
  output logic        m_axis_tuser,  // event_res
  output logic        m_axis_tlast   // tx_last
);

  logic [15:0] local_q, remote_q;
  logic        master_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        poll;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q  <= '0;
      remote_q <= '0;
      master_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLocal:  local_q  <= cfg_data_i;
        RegRemote: remote_q <= cfg_data_i;
        RegMaster: master_q <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  dnp3_lfr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .poll_o     (poll),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dnp3_lfr_datapath #(.StoreBytes(StoreBytes)) u_dp (
    .clk_i, .rst_ni,
    .local_address_i (local_q),
    .remote_address_i(remote_q),
    .master_mode_i   (master_q),
    .rx_byte_i       (s_axis_tdata),
    .poll_i          (poll),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .tx_byte_o       (m_axis_tdata),
    .tx_last_o       (m_axis_tlast),
    .event_res_o     (m_axis_tuser)
  );

endmodule
